// ===== hdl/mcfsq_pkg.sv =====
// Package with types, codes and constants of the multi-camera frame sync queue.
package mcfsq_pkg;

  localparam int CHANNELS_C = 4;
  localparam int SLOTS_PER_CHANNEL_C = 8;
  localparam int MAX_ITEMS_C = 8;

  // Request codes.
  localparam logic [2:0] REQ_PUSH    = 3'd0;
  localparam logic [2:0] REQ_RECLAIM = 3'd1;
  localparam logic [2:0] REQ_TAKE    = 3'd2;
  localparam logic [2:0] REQ_RELEASE = 3'd3;
  localparam logic [2:0] REQ_CLEAR   = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_DISABLED   = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_OCCUPIED   = 3'd3;
  localparam logic [2:0] ST_NO_FREE    = 3'd4;
  localparam logic [2:0] ST_NOT_SYNCED = 3'd5;
  localparam logic [2:0] ST_LOCK_HELD  = 3'd6;

  // Configuration register indexes.
  localparam logic CFG_TOLERANCE = 1'b0;
  localparam logic CFG_ENABLE    = 1'b1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [1:0]  channel;
    logic [31:0] capture_time_ms;
    logic [31:0] buffer_handle;
    logic        force_release;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  out_channel;
    logic [2:0]  slot;
    logic [31:0] frame_seq;
    logic [31:0] out_capture_time_ms;
    logic [31:0] out_buffer_handle;
    logic        set_complete;
    logic        last;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_PUSH_CHK,
    S_PUSH_WR,
    S_ADV,
    S_SRCH_INIT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SRCH_NEXT,
    S_COMMIT_CH,
    S_COMMIT_RET,
    S_RECL,
    S_TAKE_CHK,
    S_TAKE_CH,
    S_RPT_RD,
    S_RPT_EMIT,
    S_OUT_WAIT
  } state_t;

endpackage

// ===== hdl/mcfsq_store.sv =====
// Frame data store: sequence, timestamp and handle per slot, one port each way.
module mcfsq_store
  import mcfsq_pkg::*;
#(
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [95:0]       wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [95:0]       rd_data
);

  logic [95:0] mem [2**ADDR_W];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/multi_camera_frame_sync_queue.sv =====
// Top level of the multi-camera frame sync queue with its request sequencer.
//
// Usage: requests enter on the req channel (req_valid/req_stall), results
// leave on the rsp channel (rsp_valid/rsp_stall); the last result of a
// request has last set. Requests that give no result (unknown code, reclaim
// with nothing to free) produce nothing. Configuration writes go through
// cfg_we/cfg_index/cfg_data while the block is idle.
// One request is worked at a time; req_stall is high until it is done.
// A push writes the frame, then searches the other enabled channels for a
// synchronous set; a reclaim walks every slot of its channel; a take hands
// over the enabled channels in turn. The single read port of the frame
// store, which every timestamp compare and reported frame goes through,
// bounds the work. Results sit in an output register; while the receiver
// stalls the sequencer holds, and the next result waits. Reset clears the
// state, valid bits, counts, write pointers and locks; the working
// registers and the frame store itself are not cleared.
module multi_camera_frame_sync_queue
  import mcfsq_pkg::*;
#(
  parameter int SLOTS_PER_CHANNEL = SLOTS_PER_CHANNEL_C
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp
);

  localparam int SW = $clog2(SLOTS_PER_CHANNEL);
  localparam int AW = SW + 2;
  localparam int NS = 4 * SLOTS_PER_CHANNEL;
  localparam int CW = $clog2(SLOTS_PER_CHANNEL + 1);
  localparam logic [SW-1:0] SMAX = SW'(SLOTS_PER_CHANNEL - 1);

  state_t state, state_next;

  logic [15:0] tol;
  logic [3:0]  en_mask;

  logic [NS-1:0] sv, sr, ssy, sv_next, sr_next, ssy_next;
  logic [SW-1:0] wslot [4], wslot_next [4];
  logic [SW-1:0] gslot [4], gslot_next [4];
  logic [3:0]    gval, gval_next;
  logic [SW-1:0] yslot [4], yslot_next [4];
  logic [3:0]    yval, yval_next;
  logic [31:0]   cseq [4], cseq_next [4];
  logic [CW-1:0] vcnt [4], vcnt_next [4];

  req_t          r, r_next;
  logic [1:0]    ch, ch_next;
  logic [SW-1:0] ptr, ptr_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [SW-1:0] wref, wref_next;
  logic [SW-1:0] pick [4], pick_next [4];
  logic          older, older_next;
  logic [2:0]    rstat, rstat_next;
  logic          rset, rset_next;
  logic          rframe, rframe_next;
  logic          rlast, rlast_next;
  logic [1:0]    rch, rch_next;
  logic [SW-1:0] rslot, rslot_next;
  state_t        ret, ret_next;
  logic [31:0]   rts, rts_next;

  logic          o_valid, o_valid_next;
  rsp_t          o_data, o_data_next;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [95:0]   wr_data, rd_data;

  mcfsq_store #(.ADDR_W(AW)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign req_stall = (state != S_IDLE);
  assign rsp_valid = o_valid;
  assign rsp       = o_data;

  function automatic logic [AW-1:0] sx(input logic [1:0] c, input logic [SW-1:0] s);
    sx = {c, s};
  endfunction

  function automatic logic [SW-1:0] inc(input logic [SW-1:0] s);
    inc = (s == SMAX) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SW-1:0] dec(input logic [SW-1:0] s);
    dec = (s == '0) ? SMAX : s - 1'b1;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tol     <= '0;
      en_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOLERANCE: tol     <= cfg_data;
        CFG_ENABLE:    en_mask <= cfg_data[3:0];
        default:       ;
      endcase
    end
  end

  // Sequencer state and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      sv      <= '0;
      sr      <= '0;
      ssy     <= '0;
      gval    <= '0;
      yval    <= '0;
      o_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        wslot[i] <= '0;
        cseq[i]  <= '0;
        vcnt[i]  <= '0;
      end
    end else begin
      state   <= state_next;
      sv      <= sv_next;
      sr      <= sr_next;
      ssy     <= ssy_next;
      gval    <= gval_next;
      yval    <= yval_next;
      o_valid <= o_valid_next;
      for (int i = 0; i < 4; i++) begin
        wslot[i] <= wslot_next[i];
        cseq[i]  <= cseq_next[i];
        vcnt[i]  <= vcnt_next[i];
      end
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk) begin
    r      <= r_next;
    ch     <= ch_next;
    ptr    <= ptr_next;
    cnt    <= cnt_next;
    wref   <= wref_next;
    older  <= older_next;
    rstat  <= rstat_next;
    rset   <= rset_next;
    rframe <= rframe_next;
    rlast  <= rlast_next;
    rch    <= rch_next;
    rslot  <= rslot_next;
    ret    <= ret_next;
    rts    <= rts_next;
    o_data <= o_data_next;
    for (int i = 0; i < 4; i++) begin
      gslot[i] <= gslot_next[i];
      yslot[i] <= yslot_next[i];
      pick[i]  <= pick_next[i];
    end
  end

  // Next state and datapath control.
  always_comb begin
    logic [AW-1:0] ix;
    logic [31:0]   d;
    logic          any_more;
    logic          ready;
    state_next  = state;
    sv_next     = sv;
    sr_next     = sr;
    ssy_next    = ssy;
    gval_next   = gval;
    yval_next   = yval;
    wslot_next  = wslot;
    gslot_next  = gslot;
    yslot_next  = yslot;
    cseq_next   = cseq;
    vcnt_next   = vcnt;
    pick_next   = pick;
    r_next      = r;
    ch_next     = ch;
    ptr_next    = ptr;
    cnt_next    = cnt;
    wref_next   = wref;
    older_next  = older;
    rstat_next  = rstat;
    rset_next   = rset;
    rframe_next = rframe;
    rlast_next  = rlast;
    rch_next    = rch;
    rslot_next  = rslot;
    ret_next    = ret;
    rts_next    = rts;
    o_data_next = o_data;
    o_valid_next = o_valid && rsp_stall;
    wr_en       = 1'b0;
    wr_addr     = sx(r.channel, wslot[r.channel]);
    wr_data     = {cseq[r.channel] + 32'd1, r.capture_time_ms, r.buffer_handle};
    rd_addr     = sx(rch, rslot);
    ix          = sx(ch, ptr);
    d           = '0;
    any_more    = 1'b0;
    ready       = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          r_next     = req;
          state_next = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        rch_next    = r.channel;
        rslot_next  = '0;
        rframe_next = 1'b0;
        rset_next   = 1'b0;
        rlast_next  = 1'b1;
        rstat_next  = ST_OK;
        ret_next    = S_IDLE;
        ptr_next    = '0;
        ch_next     = '0;
        cnt_next    = '0;
        case (r.req_type)
          REQ_PUSH:    state_next = S_PUSH_CHK;
          REQ_RECLAIM: begin
            if (!en_mask[r.channel]) begin
              rstat_next = ST_DISABLED;
              state_next = S_RPT_EMIT;
            end else begin
              rlast_next = 1'b0;
              state_next = S_RECL;
            end
          end
          REQ_TAKE:    state_next = S_TAKE_CHK;
          REQ_RELEASE: begin
            gval_next  = gval & ~en_mask;
            rch_next   = '0;
            state_next = S_RPT_EMIT;
          end
          REQ_CLEAR: begin
            for (int c = 0; c < 4; c++) wslot_next[c] = '0;
            gval_next  = '0;
            yval_next  = '0;
            sr_next    = sr | sv;
            rch_next   = '0;
            state_next = S_RPT_EMIT;
          end
          default:     state_next = S_IDLE;
        endcase
      end

      S_PUSH_CHK: begin
        ix = sx(r.channel, wslot[r.channel]);
        if (!en_mask[r.channel]) begin
          rstat_next = ST_DISABLED;
          state_next = S_RPT_EMIT;
        end else if (vcnt[r.channel] >= CW'(SLOTS_PER_CHANNEL)) begin
          rstat_next = ST_FULL;
          state_next = S_RPT_EMIT;
        end else if (sv[ix]) begin
          rstat_next = ST_OCCUPIED;
          state_next = S_RPT_EMIT;
        end else begin
          state_next = S_PUSH_WR;
        end
      end

      S_PUSH_WR: begin
        ix = sx(r.channel, wslot[r.channel]);
        wr_en     = 1'b1;
        sv_next[ix]  = 1'b1;
        sr_next[ix]  = 1'b0;
        ssy_next[ix] = 1'b0;
        cseq_next[r.channel] = cseq[r.channel] + 32'd1;
        vcnt_next[r.channel] = vcnt[r.channel] + 1'b1;
        wref_next  = wslot[r.channel];
        rslot_next = wslot[r.channel];
        rframe_next = 1'b1;
        cnt_next   = '0;
        state_next = S_ADV;
      end

      // One advance step per cycle, skipping the GPU-locked slot.
      S_ADV: begin
        ptr_next = inc(wslot[r.channel]);
        wslot_next[r.channel] = inc(wslot[r.channel]);
        ix = sx(r.channel, inc(wslot[r.channel]));
        if (gval[r.channel] && inc(wslot[r.channel]) == gslot[r.channel]) begin
          cnt_next = cnt + 1'b1;
          if (cnt + 1'b1 >= CW'(SLOTS_PER_CHANNEL - 1)) begin
            rstat_next = ST_NO_FREE;
            state_next = S_RPT_RD;
          end
        end else begin
          if (sv[ix]) begin
            sr_next[ix]  = 1'b1;
            ssy_next[ix] = 1'b0;
          end
          rts_next   = r.capture_time_ms;
          pick_next[r.channel] = wref;
          ch_next    = '0;
          state_next = S_SRCH_INIT;
        end
      end

      S_SRCH_INIT: begin
        ptr_next = wslot[ch];
        cnt_next = '0;
        if (ch == r.channel || !en_mask[ch]) begin
          if (ch == 2'd3) begin
            ch_next    = '0;
            state_next = S_COMMIT_CH;
          end else begin
            ch_next = ch + 1'b1;
          end
        end else if (vcnt[ch] == '0) begin
          state_next = S_RPT_RD;
        end else begin
          state_next = S_SRCH_RD;
        end
      end

      S_SRCH_RD: begin
        ptr_next = dec(ptr);
        ix = sx(ch, dec(ptr));
        cnt_next = cnt + 1'b1;
        if ((gval[ch] && dec(ptr) == gslot[ch]) || !sv[ix] || sr[ix] || ssy[ix]) begin
          state_next = S_SRCH_NEXT;
        end else begin
          rd_addr    = ix;
          state_next = S_SRCH_CMP;
        end
      end

      S_SRCH_CMP: begin
        d = (rts > rd_data[63:32]) ? rts - rd_data[63:32] : rd_data[63:32] - rts;
        if (d <= {16'd0, tol}) begin
          pick_next[ch] = ptr;
          if (ch == 2'd3) begin
            ch_next    = '0;
            state_next = S_COMMIT_CH;
          end else begin
            ch_next    = ch + 1'b1;
            state_next = S_SRCH_INIT;
          end
        end else begin
          state_next = S_SRCH_NEXT;
        end
      end

      S_SRCH_NEXT: begin
        if (cnt >= vcnt[ch]) begin
          state_next = S_RPT_RD;
        end else begin
          state_next = S_SRCH_RD;
        end
      end

      // Commit the set one channel at a time.
      S_COMMIT_CH: begin
        ptr_next   = wslot[ch];
        cnt_next   = '0;
        older_next = 1'b0;
        if (ch != r.channel && !en_mask[ch]) begin
          yval_next[ch] = 1'b0;
          any_more = 1'b1;
        end else begin
          yslot_next[ch] = pick[ch];
          yval_next[ch]  = 1'b1;
          ssy_next[sx(ch, pick[ch])] = 1'b1;
          state_next = S_COMMIT_RET;
        end
        if (any_more) begin
          if (ch == 2'd3) begin
            rset_next  = 1'b1;
            state_next = S_RPT_RD;
          end else begin
            ch_next = ch + 1'b1;
          end
        end
      end

      S_COMMIT_RET: begin
        if (cnt >= vcnt[ch]) begin
          if (ch == 2'd3) begin
            rset_next  = 1'b1;
            state_next = S_RPT_RD;
          end else begin
            ch_next    = ch + 1'b1;
            state_next = S_COMMIT_CH;
          end
        end else begin
          ptr_next = dec(ptr);
          cnt_next = cnt + 1'b1;
          ix = sx(ch, dec(ptr));
          if (dec(ptr) == pick[ch]) begin
            older_next = 1'b1;
          end else if (older && sv[ix] && !(gval[ch] && dec(ptr) == gslot[ch])) begin
            sr_next[ix]  = 1'b1;
            ssy_next[ix] = 1'b0;
          end
        end
      end

      // Reclaim walks slots in order, one per cycle while no freed slot is being reported.
      S_RECL: begin
        ix = sx(r.channel, ptr);
        if (sr[ix] && sv[ix]) begin
          sr_next[ix]  = 1'b0;
          sv_next[ix]  = 1'b0;
          ssy_next[ix] = 1'b0;
          if (vcnt[r.channel] != '0) vcnt_next[r.channel] = vcnt[r.channel] - 1'b1;
          rslot_next  = ptr;
          rframe_next = 1'b1;
          rstat_next  = ST_OK;
          ret_next    = S_RECL;
          any_more    = 1'b0;
          for (int s = 0; s < SLOTS_PER_CHANNEL; s++) begin
            if (SW'(s) > ptr && sr[sx(r.channel, SW'(s))] && sv[sx(r.channel, SW'(s))]) begin
              any_more = 1'b1;
            end
          end
          rlast_next = !any_more;
          state_next = S_RPT_RD;
        end
        if (ptr == SMAX) begin
          if (!(sr[ix] && sv[ix])) state_next = S_IDLE;
          else if (!any_more) ret_next = S_IDLE;
        end
        ptr_next = inc(ptr);
        if (sr[ix] && sv[ix] && !any_more) ret_next = S_IDLE;
      end

      S_TAKE_CHK: begin
        ready = (en_mask != 4'd0);
        for (int c = 0; c < 4; c++) begin
          if (en_mask[c] && (!yval[c] || vcnt[c] == '0)) ready = 1'b0;
        end
        if (!ready) begin
          rch_next   = '0;
          rstat_next = ST_NOT_SYNCED;
          state_next = S_RPT_EMIT;
        end else begin
          ch_next    = '0;
          state_next = S_TAKE_CH;
        end
      end

      // Hand over one channel per pass.
      S_TAKE_CH: begin
        rch_next    = ch;
        rlast_next  = 1'b1;
        for (int c = 0; c < 4; c++) begin
          if (c > ch && en_mask[c]) rlast_next = 1'b0;
        end
        if (!en_mask[ch]) begin
          if (ch == 2'd3) state_next = S_IDLE;
          else ch_next = ch + 1'b1;
        end else if (gval[ch] && !r.force_release) begin
          rstat_next  = ST_LOCK_HELD;
          rframe_next = 1'b0;
          rlast_next  = 1'b1;
          ret_next    = S_IDLE;
          state_next  = S_RPT_EMIT;
        end else begin
          gslot_next[ch] = yslot[ch];
          gval_next[ch]  = 1'b1;
          yval_next[ch]  = 1'b0;
          rslot_next     = yslot[ch];
          rframe_next    = 1'b1;
          rstat_next     = ST_OK;
          ret_next       = (ch == 2'd3 || rlast_next) ? S_IDLE : S_TAKE_CH;
          ch_next        = ch + 1'b1;
          state_next     = S_RPT_RD;
        end
      end

      S_RPT_RD: begin
        rd_addr = sx(rch, rslot);
        rch_next = rch;
        if (state == S_RPT_RD && r.req_type == REQ_PUSH) begin
          rch_next = r.channel;
          rslot_next = wref;
          rframe_next = 1'b1;
          rlast_next = 1'b1;
          ret_next = S_IDLE;
          rd_addr = sx(r.channel, wref);
        end
        state_next = S_RPT_EMIT;
      end

      // Load the output register once it is free.
      S_RPT_EMIT: begin
        if (!o_valid || !rsp_stall) begin
          o_valid_next = 1'b1;
          o_data_next.status       = rstat;
          o_data_next.out_channel  = rch;
          o_data_next.slot         = rframe ? 3'(rslot) : 3'd0;
          o_data_next.frame_seq    = rframe ? rd_data[95:64] : 32'd0;
          o_data_next.out_capture_time_ms = rframe ? rd_data[63:32] : 32'd0;
          o_data_next.out_buffer_handle   = rframe ? rd_data[31:0] : 32'd0;
          o_data_next.set_complete = rset;
          o_data_next.last         = rlast;
          state_next = ret;
        end
      end

      S_OUT_WAIT: state_next = S_IDLE;

      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== verif/multi_camera_frame_sync_queue_test.sv =====
// Self-checking testbench for the multi-camera frame sync queue.
module multi_camera_frame_sync_queue_test;
  import mcfsq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = CHANNELS_C;
  localparam int NSLOT = SLOTS_PER_CHANNEL_C;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 300;

  // Scoreboard: tracks the frame rings and locks, predicts every result and
  // compares each result transfer with the oldest prediction.
  class frame_sync_scoreboard;
    bit          frame_valid[NCH][NSLOT];
    bit          frame_retired[NCH][NSLOT];
    bit          frame_synced[NCH][NSLOT];
    logic [31:0] frame_seq_q[NCH][NSLOT];
    logic [31:0] frame_time[NCH][NSLOT];
    logic [31:0] frame_handle[NCH][NSLOT];
    bit   [2:0]  wr_ptr[NCH];
    bit   [2:0]  gpu_slot[NCH];
    bit          gpu_held[NCH];
    bit   [2:0]  sync_slot[NCH];
    bit          sync_held[NCH];
    logic [31:0] ch_seq[NCH];
    int          frame_count[NCH];
    logic [15:0] tolerance;
    logic [3:0]  enable_mask;
    rsp_t        expected_rsp[$];
    int          errors;

    function void report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function rsp_t frame_rsp(logic [2:0] st, int c, bit has, bit [2:0] s, bit set);
      rsp_t r;
      r = '0;
      r.status = st;
      r.out_channel = c[1:0];
      if (has) begin
        r.slot = s;
        r.frame_seq = frame_seq_q[c][s];
        r.out_capture_time_ms = frame_time[c][s];
        r.out_buffer_handle = frame_handle[c][s];
      end
      r.set_complete = set;
      return r;
    endfunction

    // Move the write pointer on, skipping the GPU-locked slot.
    function bit advance_write(int c);
      bit [2:0] w;
      for (int n = 0; n + 1 < NSLOT; n++) begin
        w = wr_ptr[c] + 3'd1;
        wr_ptr[c] = w;
        if (gpu_held[c] && w == gpu_slot[c]) continue;
        if (frame_valid[c][w]) begin
          frame_retired[c][w] = 1;
          frame_synced[c][w] = 0;
        end
        return 1;
      end
      return 0;
    endfunction

    // Search the other enabled channels, newest first, for matching frames.
    function bit match_set(int ref_ch, bit [2:0] ref_slot);
      bit [2:0]    pick[NCH];
      bit          has[NCH];
      bit [2:0]    p;
      logic [31:0] rts, d;
      bit          older;
      rts = frame_time[ref_ch][ref_slot];
      for (int c = 0; c < NCH; c++) begin
        p = wr_ptr[c];
        has[c] = 0;
        pick[c] = 0;
        if (c == ref_ch) begin
          pick[c] = ref_slot;
          has[c] = 1;
          continue;
        end
        if (!enable_mask[c]) continue;
        for (int j = 0; j < frame_count[c]; j++) begin
          p = p - 3'd1;
          if (gpu_held[c] && p == gpu_slot[c]) continue;
          if (!frame_valid[c][p] || frame_retired[c][p] || frame_synced[c][p]) continue;
          d = rts > frame_time[c][p] ? rts - frame_time[c][p] : frame_time[c][p] - rts;
          if (d <= {16'd0, tolerance}) begin
            pick[c] = p;
            has[c] = 1;
            break;
          end
        end
        if (!has[c]) return 0;
      end
      // Lock the set and retire everything older than the picked frames.
      for (int c = 0; c < NCH; c++) begin
        p = wr_ptr[c];
        older = 0;
        if (!has[c]) begin
          sync_held[c] = 0;
          continue;
        end
        sync_slot[c] = pick[c];
        sync_held[c] = 1;
        frame_synced[c][pick[c]] = 1;
        for (int j = 0; j < frame_count[c]; j++) begin
          p = p - 3'd1;
          if (p == pick[c]) begin
            older = 1;
            continue;
          end
          if (older && frame_valid[c][p] && !(gpu_held[c] && p == gpu_slot[c])) begin
            frame_retired[c][p] = 1;
            frame_synced[c][p] = 0;
          end
        end
      end
      return 1;
    endfunction

    function void reset_state();
      tolerance = '0;
      enable_mask = '0;
      for (int c = 0; c < NCH; c++) begin
        wr_ptr[c] = 0;
        gpu_held[c] = 0;
        sync_held[c] = 0;
        gpu_slot[c] = 0;
        sync_slot[c] = 0;
        ch_seq[c] = 0;
        frame_count[c] = 0;
        for (int s = 0; s < NSLOT; s++) begin
          frame_valid[c][s] = 0;
          frame_retired[c][s] = 0;
          frame_synced[c][s] = 0;
        end
      end
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    // Note an accepted request and queue the results it causes.
    function void note_request(req_t r);
      rsp_t     res[$];
      int       c;
      bit [2:0] w;
      bit       ready;
      c = r.channel;
      case (r.req_type)
        REQ_PUSH: begin
          if (!enable_mask[c]) res.push_back(frame_rsp(ST_DISABLED, c, 0, 0, 0));
          else if (frame_count[c] >= NSLOT) res.push_back(frame_rsp(ST_FULL, c, 0, 0, 0));
          else if (frame_valid[c][wr_ptr[c]]) begin
            res.push_back(frame_rsp(ST_OCCUPIED, c, 0, 0, 0));
          end else begin
            w = wr_ptr[c];
            frame_seq_q[c][w] = ch_seq[c] + 1;
            frame_valid[c][w] = 1;
            frame_retired[c][w] = 0;
            frame_synced[c][w] = 0;
            frame_time[c][w] = r.capture_time_ms;
            frame_handle[c][w] = r.buffer_handle;
            ch_seq[c] = ch_seq[c] + 1;
            frame_count[c]++;
            if (!advance_write(c)) res.push_back(frame_rsp(ST_NO_FREE, c, 1, w, 0));
            else res.push_back(frame_rsp(ST_OK, c, 1, w, match_set(c, w)));
          end
        end
        REQ_RECLAIM: begin
          if (!enable_mask[c]) res.push_back(frame_rsp(ST_DISABLED, c, 0, 0, 0));
          else begin
            for (int s = 0; s < NSLOT && res.size() < MAX_ITEMS_C; s++) begin
              if (frame_retired[c][s] && frame_valid[c][s]) begin
                frame_retired[c][s] = 0;
                frame_valid[c][s] = 0;
                frame_synced[c][s] = 0;
                if (frame_count[c] > 0) frame_count[c]--;
                res.push_back(frame_rsp(ST_OK, c, 1, s[2:0], 0));
              end
            end
          end
        end
        REQ_TAKE: begin
          ready = enable_mask != 0;
          for (int k = 0; k < NCH; k++) begin
            if (enable_mask[k] && (!sync_held[k] || frame_count[k] == 0)) ready = 0;
          end
          if (!ready) res.push_back(frame_rsp(ST_NOT_SYNCED, 0, 0, 0, 0));
          else begin
            for (int k = 0; k < NCH; k++) begin
              if (!enable_mask[k]) continue;
              if (gpu_held[k] && !r.force_release) begin
                res.push_back(frame_rsp(ST_LOCK_HELD, k, 0, 0, 0));
                break;
              end
              gpu_slot[k] = sync_slot[k];
              gpu_held[k] = 1;
              sync_held[k] = 0;
              res.push_back(frame_rsp(ST_OK, k, 1, gpu_slot[k], 0));
            end
          end
        end
        REQ_RELEASE: begin
          for (int k = 0; k < NCH; k++) if (enable_mask[k]) gpu_held[k] = 0;
          res.push_back(frame_rsp(ST_OK, 0, 0, 0, 0));
        end
        REQ_CLEAR: begin
          for (int k = 0; k < NCH; k++) begin
            wr_ptr[k] = 0;
            gpu_held[k] = 0;
            sync_held[k] = 0;
            for (int s = 0; s < NSLOT; s++) if (frame_valid[k][s]) frame_retired[k][s] = 1;
          end
          res.push_back(frame_rsp(ST_OK, 0, 0, 0, 0));
        end
        default: ;
      endcase
      if (res.size() > 0) res[res.size() - 1].last = 1;
      foreach (res[i]) expected_rsp.push_back(res[i]);
    endfunction

    function void check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endfunction

    // Compare one result transfer with the oldest prediction.
    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = expected_rsp.pop_front();
      check_field("status", got.status, want.status);
      check_field("out_channel", got.out_channel, want.out_channel);
      check_field("slot", got.slot, want.slot);
      check_field("frame_seq", got.frame_seq, want.frame_seq);
      check_field("capture_time", got.out_capture_time_ms, want.out_capture_time_ms);
      check_field("buffer_handle", got.out_buffer_handle, want.out_buffer_handle);
      check_field("set_complete", got.set_complete, want.set_complete);
      check_field("last", got.last, want.last);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;

  frame_sync_scoreboard sb;
  int          send_idle_pct;
  int          stall_pct;
  logic [3:0]  cur_mask;
  logic [31:0] time_base;
  bit          req_fire;
  bit          rsp_fire;
  rsp_t        rsp_seen;
  int          quiet_cycles;

  multi_camera_frame_sync_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sample both channels mid-cycle, where everything has settled.
  always @(negedge clk) begin
    req_fire = !rst && req_valid && !req_stall;
    rsp_fire = !rst && rsp_valid && !rsp_stall;
    rsp_seen = rsp;
  end

  // Result side: check each transfer and stall at random.
  always @(posedge clk) begin
    if (rsp_fire) sb.check_result(rsp_seen);
    rsp_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || req_fire || rsp_fire) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic req_t make_req(logic [2:0] kind, logic [1:0] ch, logic [31:0] ts,
                                    logic [31:0] h, logic f);
    req_t r;
    r.req_type = kind;
    r.channel = ch;
    r.capture_time_ms = ts;
    r.buffer_handle = h;
    r.force_release = f;
    return r;
  endfunction

  // Hold one request until its transfer, then maybe leave a gap.
  task automatic send_req(req_t r);
    req <= r;
    req_valid <= 1'b1;
    do begin
      @(negedge clk);
      @(posedge clk);
    end while (!req_fire);
    sb.note_request(r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Drain all results, let any silent request finish, then write both registers.
  task automatic set_config(logic [15:0] tol, logic [3:0] mask);
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TOLERANCE;
    cfg_data <= tol;
    @(posedge clk);
    cfg_index <= CFG_ENABLE;
    cfg_data <= {12'd0, mask};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.tolerance = tol;
    sb.enable_mask = mask;
    cur_mask = mask;
  endtask

  // One random request; mostly pushes of nearly simultaneous frames.
  task automatic random_req(output bit counted);
    int          pick;
    logic [1:0]  ch;
    logic [31:0] ts;
    pick = $urandom_range(0, 99);
    ch = $urandom_range(0, 3);
    if ($urandom_range(0, 9) != 0) begin
      repeat (8) if (!cur_mask[ch]) ch = $urandom_range(0, 3);
    end
    counted = 1;
    if (pick < 60) begin
      time_base = time_base + $urandom_range(0, 30);
      ts = ($urandom_range(0, 19) == 0) ? $urandom : time_base + $urandom_range(0, 20);
      send_req(make_req(REQ_PUSH, ch, ts, $urandom, $urandom_range(0, 1)));
    end else if (pick < 75) begin
      send_req(make_req(REQ_RECLAIM, ch, $urandom, $urandom, $urandom_range(0, 1)));
    end else if (pick < 86) begin
      send_req(make_req(REQ_TAKE, ch, $urandom, $urandom, $urandom_range(0, 1)));
    end else if (pick < 92) begin
      send_req(make_req(REQ_RELEASE, ch, $urandom, $urandom, $urandom_range(0, 1)));
    end else if (pick < 95) begin
      send_req(make_req(REQ_CLEAR, ch, $urandom, $urandom, $urandom_range(0, 1)));
    end else begin
      counted = 0;
      send_req(make_req($urandom_range(5, 7), ch, $urandom, $urandom, $urandom_range(0, 1)));
    end
  endtask

  // Main sequence.
  initial begin
    logic [15:0] tol_set[4];
    logic [3:0]  mask_set[4];
    int          send_set[4];
    int          stall_set[4];
    int          done_items;
    bit          counted;
    sb = new();
    sb.errors = 0;
    sb.reset_state();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_TOLERANCE;
    cfg_data = '0;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    cur_mask = '0;
    time_base = 32'd5000;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: everything disabled right after reset.
    send_req(make_req(REQ_PUSH, 2'd0, 32'd10, 32'd1, 1'b0));
    send_req(make_req(REQ_RECLAIM, 2'd2, 32'd0, 32'd0, 1'b0));
    send_req(make_req(REQ_TAKE, 2'd0, 32'd0, 32'd0, 1'b1));
    send_req(make_req(REQ_RELEASE, 2'd3, 32'd0, 32'd0, 1'b0));
    send_req(make_req(REQ_CLEAR, 2'd1, 32'd0, 32'd0, 1'b0));
    send_req(make_req(3'd7, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));

    // Directed: full synchronous sets, take with and without a held lock.
    set_config(16'd3, 4'hF);
    for (int c = 0; c < NCH; c++)
      send_req(make_req(REQ_PUSH, c[1:0], 32'd1000 + c, (c == 1) ? 32'hFFFF_FFFF : c, 1'b0));
    send_req(make_req(REQ_TAKE, 2'd0, 32'd0, 32'd0, 1'b0));
    for (int c = 0; c < NCH; c++)
      send_req(make_req(REQ_PUSH, c[1:0], 32'd2003 - c, 32'hA5A5_0000 + c, 1'b0));
    send_req(make_req(REQ_TAKE, 2'd0, 32'd0, 32'd0, 1'b0));
    send_req(make_req(REQ_TAKE, 2'd0, 32'd0, 32'd0, 1'b1));
    send_req(make_req(REQ_RELEASE, 2'd0, 32'd0, 32'd0, 1'b0));
    send_req(make_req(REQ_PUSH, 2'd2, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 1'b0));
    send_req(make_req(REQ_PUSH, 2'd2, 32'd0, 32'd0, 1'b0));
    send_req(make_req(REQ_RECLAIM, 2'd0, 32'd0, 32'd0, 1'b0));
    send_req(make_req(REQ_CLEAR, 2'd0, 32'd0, 32'd0, 1'b0));
    send_req(make_req(REQ_RECLAIM, 2'd1, 32'd0, 32'd0, 1'b0));
    send_req(make_req(3'd5, 2'd1, 32'd0, 32'd0, 1'b0));
    send_req(make_req(3'd6, 2'd2, 32'd0, 32'd0, 1'b1));

    // Random phases with different settings and idling patterns.
    tol_set = '{16'd10, 16'd0, 16'hFFFF, 16'd40};
    mask_set = '{4'hF, 4'b0101, 4'b1010, 4'b1011};
    send_set = '{0, 62, 0, 27};
    stall_set = '{0, 0, 62, 27};
    for (int ph = 0; ph < 4; ph++) begin
      set_config(tol_set[ph], mask_set[ph]);
      send_idle_pct = send_set[ph];
      stall_pct = stall_set[ph];
      done_items = 0;
      while (done_items < 28) begin
        random_req(counted);
        if (counted) done_items++;
      end
    end

    // Wait for every result, then let the block settle.
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
